[design/acp_pkg.sv]
// Shared types, constants and command name table for the command line parser.
`default_nettype none
package acp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int MAX_TOKENS_DEF = 10;
    localparam int NUM_NAMES      = 7;
    localparam int NUM_ARGS       = 7;
    localparam int NAME_MAX_LEN   = 11;
    localparam int ARG_W          = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

    typedef logic [NUM_NAMES-1:0] t_name_mask;
    typedef logic [2:0]           t_command;
    typedef logic [3:0]           t_name_pos;

    typedef struct packed {
        t_command                           command;
        logic [3:0]                         arg_count;
        logic [NUM_ARGS-1:0][ARG_W-1:0]     args;
    } t_result;

    // names are right-justified in the vector, first character highest
    localparam logic [8*NAME_MAX_LEN-1:0] NAME_TAB [NUM_NAMES] = '{
        88'("setTime"),
        88'("setConfig"),
        88'("setAlarm"),
        88'("setDataMode"),
        88'("getConfig"),
        88'("getAlarm"),
        88'("getStep")
    };

    localparam t_name_pos NAME_LEN [NUM_NAMES] = '{
        4'd7, 4'd9, 4'd8, 4'd11, 4'd9, 4'd8, 4'd7
    };

    function automatic logic [7:0] name_char(input int idx, input t_name_pos pos);
        int sh;
        logic [7:0] ch;
        sh = 0;
        ch = CHAR_NUL;
        if (pos < NAME_LEN[idx]) begin
            sh = (int'(NAME_LEN[idx]) - 1 - int'(pos)) * 8;
            ch = NAME_TAB[idx][sh +: 8];
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

[design/acp_parse.sv]
// Line state and per-byte parsing: tokens, command name match, argument values.
`default_nettype none
module acp_parse #(
    parameter int LINE_BYTES = acp_pkg::LINE_BYTES_DEF,
    parameter int MAX_TOKENS = acp_pkg::MAX_TOKENS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_found,
    output acp_pkg::t_result      o_result
);

    localparam int LW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int AW = $clog2(acp_pkg::NUM_ARGS);
    localparam int PW = 22;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_STOP  = 2'd2;

    logic [LW-1:0]              r_len, n_len;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_inside, n_inside;
    logic                       r_ended, n_ended;
    acp_pkg::t_name_mask        r_cand, n_cand;
    acp_pkg::t_name_pos         r_pos, n_pos;
    logic [acp_pkg::ARG_W-1:0]  r_args [acp_pkg::NUM_ARGS];
    logic [acp_pkg::ARG_W-1:0]  n_args [acp_pkg::NUM_ARGS];
    logic [1:0]                 r_phase, n_phase;
    logic                       r_neg, n_neg;

    logic                       is_term, is_digit, is_tok;
    logic                       tok_start, tok_keep;
    logic [CW-1:0]              cnt_cur;
    logic [1:0]                 phase_cur;
    logic                       neg_cur;
    logic                       arg_slot;
    logic [AW-1:0]              arg_idx;
    logic [acp_pkg::ARG_W-1:0]  arg_cur;
    logic signed [PW-1:0]       prod, acc;
    logic [3:0]                 digit;
    logic [acp_pkg::ARG_W-1:0]  arg_sat;
    logic                       hit;
    acp_pkg::t_command          hit_idx;

    assign is_term  = (i_byte == acp_pkg::CHAR_CR) || (i_byte == acp_pkg::CHAR_LF);
    assign is_digit = (i_byte >= acp_pkg::CHAR_0) && (i_byte <= acp_pkg::CHAR_9);
    assign is_tok   = is_digit
                   || ((i_byte >= acp_pkg::CHAR_UC_A) && (i_byte <= acp_pkg::CHAR_UC_Z))
                   || ((i_byte >= acp_pkg::CHAR_LC_A) && (i_byte <= acp_pkg::CHAR_LC_Z))
                   || (i_byte == acp_pkg::CHAR_MINUS) || (i_byte == acp_pkg::CHAR_DOT);

    assign tok_start = !r_inside;
    assign tok_keep  = r_inside || (r_count < CW'(MAX_TOKENS));
    assign cnt_cur   = tok_start ? r_count + CW'(1) : r_count;
    assign phase_cur = tok_start ? PH_START : r_phase;
    assign neg_cur   = tok_start ? 1'b0 : r_neg;

    // argument tokens are tokens 2..8 of the line
    assign arg_slot = (cnt_cur >= CW'(2)) && (cnt_cur <= CW'(acp_pkg::NUM_ARGS + 1));
    assign arg_idx  = AW'(cnt_cur - CW'(2));
    assign arg_cur  = arg_slot ? r_args[arg_idx] : '0;

    assign digit = 4'(i_byte - acp_pkg::CHAR_0);
    assign prod  = PW'($signed(arg_cur)) * PW'(10);
    assign acc   = neg_cur ? prod - PW'(digit) : prod + PW'(digit);

    always_comb begin
        if (acc < -PW'(32768)) begin
            arg_sat = 16'h8000;
        end else if (acc > PW'(32767)) begin
            arg_sat = 16'h7FFF;
        end else begin
            arg_sat = acc[acp_pkg::ARG_W-1:0];
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = acp_pkg::NUM_NAMES - 1; i >= 0; i--) begin
            if (r_cand[i] && (r_pos == acp_pkg::NAME_LEN[i])) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    always_comb begin
        n_len    = r_len;
        n_count  = r_count;
        n_inside = r_inside;
        n_ended  = r_ended;
        n_cand   = r_cand;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_neg    = r_neg;
        for (int i = 0; i < acp_pkg::NUM_ARGS; i++) begin
            n_args[i] = r_args[i];
        end
        o_found = 1'b0;

        o_result.command   = hit_idx;
        o_result.arg_count = 4'(r_count - CW'(1));
        for (int i = 0; i < acp_pkg::NUM_ARGS; i++) begin
            o_result.args[i] = r_args[i];
        end

        if (i_step) begin
            if (is_term || (r_len == LW'(LINE_BYTES - 1))) begin
                o_found  = is_term && (r_count != '0) && hit;
                n_len    = '0;
                n_count  = '0;
                n_inside = 1'b0;
                n_ended  = 1'b0;
                n_cand   = '1;
                n_pos    = '0;
                n_phase  = PH_START;
                n_neg    = 1'b0;
                for (int i = 0; i < acp_pkg::NUM_ARGS; i++) begin
                    n_args[i] = '0;
                end
            end else begin
                n_len = r_len + LW'(1);
                if (!r_ended) begin
                    if (i_byte == acp_pkg::CHAR_NUL) begin
                        n_ended  = 1'b1;
                        n_inside = 1'b0;
                    end else if (!is_tok) begin
                        n_inside = 1'b0;
                    end else if (tok_keep) begin
                        n_count  = cnt_cur;
                        n_inside = 1'b1;
                        n_phase  = phase_cur;
                        n_neg    = neg_cur;
                        if (cnt_cur == CW'(1)) begin
                            for (int i = 0; i < acp_pkg::NUM_NAMES; i++) begin
                                if (acp_pkg::name_char(i, r_pos) != i_byte) begin
                                    n_cand[i] = 1'b0;
                                end
                            end
                            if (r_pos != '1) begin
                                n_pos = r_pos + 4'd1;
                            end
                        end else if (arg_slot && (phase_cur != PH_STOP)) begin
                            if (is_digit) begin
                                n_args[arg_idx] = arg_sat;
                                n_phase         = PH_DIGIT;
                            end else if ((i_byte == acp_pkg::CHAR_MINUS)
                                         && (phase_cur == PH_START)) begin
                                n_neg   = 1'b1;
                                n_phase = PH_DIGIT;
                            end else begin
                                n_phase = PH_STOP;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_count  <= '0;
            r_inside <= 1'b0;
            r_ended  <= 1'b0;
            r_cand   <= '1;
            r_pos    <= '0;
            r_phase  <= PH_START;
            r_neg    <= 1'b0;
            for (int i = 0; i < acp_pkg::NUM_ARGS; i++) begin
                r_args[i] <= '0;
            end
        end else begin
            r_len    <= n_len;
            r_count  <= n_count;
            r_inside <= n_inside;
            r_ended  <= n_ended;
            r_cand   <= n_cand;
            r_pos    <= n_pos;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            for (int i = 0; i < acp_pkg::NUM_ARGS; i++) begin
                r_args[i] <= n_args[i];
            end
        end
    end

endmodule
`default_nettype wire

[design/ascii_command_line_parser_unit.sv]
// Top level: byte input register, parser core and result register.
// A CR or LF word passes the input register, then the parser core sets the result register.
// Throughput: one byte word per cycle while the output is not stalled by i_stall.
// The input register keeps taking words while a result waits, until it holds one unprocessed word.
// Synchronous active-low reset clears the line state, the input register and any pending result.
`default_nettype none
module ascii_command_line_parser_unit #(
    parameter int LINE_BYTES = acp_pkg::LINE_BYTES_DEF,
    parameter int MAX_TOKENS = acp_pkg::MAX_TOKENS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_command,
    output logic [3:0]              o_arg_count,
    output logic signed [15:0]      o_arg_1,
    output logic signed [15:0]      o_arg_2,
    output logic signed [15:0]      o_arg_3,
    output logic signed [15:0]      o_arg_4,
    output logic signed [15:0]      o_arg_5,
    output logic signed [15:0]      o_arg_6,
    output logic signed [15:0]      o_arg_7
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    acp_pkg::t_result   r_res;

    logic               advance;
    logic               accept;
    logic               step;
    logic               found;
    acp_pkg::t_result   res;

    assign advance = !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign step    = r_in_valid && advance;

    acp_parse #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_found  (found),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (step && found) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (step && found) begin
            r_res <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_command   = r_res.command;
    assign o_arg_count = r_res.arg_count;
    assign o_arg_1     = $signed(r_res.args[0]);
    assign o_arg_2     = $signed(r_res.args[1]);
    assign o_arg_3     = $signed(r_res.args[2]);
    assign o_arg_4     = $signed(r_res.args[3]);
    assign o_arg_5     = $signed(r_res.args[4]);
    assign o_arg_6     = $signed(r_res.args[5]);
    assign o_arg_7     = $signed(r_res.args[6]);

endmodule
`default_nettype wire
